// ===== rtl/e2c_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and a helper function of the epoch-to-calendar core.
// No dependencies; compile this file first.
package e2c_pkg;

    localparam int C_SECONDS_WIDTH = 40;

    // 86400 = 2^7 * 675: the power-of-two part is a plain shift
    localparam int C_SEC_DAY_SHIFT = 7;
    localparam int C_SEC_DAY_ODD   = 675;
    localparam int C_SHIFT_MARCH   = 719468;
    localparam int C_DAYS_400Y     = 146097;
    localparam int C_YEAR_MUL      = 2939745;
    localparam int C_MONTH_MUL     = 2141;
    localparam int C_MONTH_ADD     = 132377;
    localparam int C_JAN_DOY       = 306;
    localparam int C_JAN_FEB_DAYS  = 59;
    localparam int C_SEC_HOUR      = 3600;
    localparam int C_SEC_MIN       = 60;
    localparam int C_WDAY_OFFSET   = 4;

    // Low chunk widths of the two-step long divisions
    localparam int C_DAYS_LO = 20;
    localparam int C_N1_LO   = 12;

    // Register stages from input transfer to output register
    localparam int C_LATENCY = 14;
    // First stage that carries the time of day as one bundle
    localparam int C_STG_TOD = 9;

    typedef struct packed {
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // Quotient width of a w-bit dividend over a divisor of db bits
    function automatic int f_quot_width(input int w, input int db);
        return (w >= db) ? w - db + 1 : 1;
    endfunction

endpackage

// ===== rtl/e2c_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the epoch-to-calendar core.
// Depends on e2c_pkg for the default seconds width.
interface e2c_in_if #(
    parameter int SECONDS_WIDTH = e2c_pkg::C_SECONDS_WIDTH
) ();
    logic                     valid;
    logic                     ready;
    logic [SECONDS_WIDTH-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_out_if ();
    logic        valid;
    logic        ready;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [8:0]  year_day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day_of_month,
                    output year_day, output weekday, output hour, output minute,
                    output second, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input year_day, input weekday, input hour, input minute,
                    input second, output ready);
endinterface

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
`timescale 1ns / 1ps
// Epoch seconds to Gregorian date and time of day, fully pipelined.
// Input channel i_in carries epoch_seconds; output channel o_out carries the year,
// month (0 = January), day of month, day of year, weekday (0 = Sunday), hour,
// minute and second of that instant. Both channels transfer on valid and ready.
// Throughput is one item per clock while o_out is not stalled. There are 14
// register stages: the input transfer loads stage 1 and stage 14 is the output
// register, from which the result transfers out on valid and ready. The
// depth is set by four two-stage constant dividers in series (days split in two
// chunks, century split in two chunks), the year-of-century, day-of-year and
// month stages, the two-stage day-of-month divider and the output register.
// Each stage holds a valid bit; a stage loads
// whenever it or any later stage is empty or the output is taken, so bubbles
// close up and input is still taken while a result waits at the output.
// When o_out.ready is low and every stage is full, i_in.ready drops and all
// data holds in place. Reset clears the valid bits only; the pipeline is then
// empty and ready at once.
// Depends on e2c_pkg, e2c_if and e2c_cdiv.
module epoch_seconds_to_calendar_core #(
    parameter int SECONDS_WIDTH = e2c_pkg::C_SECONDS_WIDTH
) (
    input logic       i_clk,
    input logic       i_rst_n,
    e2c_in_if.sink    i_in,
    e2c_out_if.source o_out
);
    import e2c_pkg::*;

    localparam int LAT      = C_LATENCY;
    localparam int LOW_BITS = C_DAYS_LO + C_SEC_DAY_SHIFT;
    localparam int HW       = SECONDS_WIDTH - LOW_BITS;
    localparam int DW       = SECONDS_WIDTH - 16;
    localparam int RDAY     = $clog2(C_SEC_DAY_ODD);
    localparam int QA       = f_quot_width(HW, RDAY);
    localparam int WDL      = RDAY + C_DAYS_LO;
    localparam int QDL      = f_quot_width(WDL, RDAY);
    localparam int SECW     = RDAY + C_SEC_DAY_SHIFT;
    localparam int N1W      = ((DW > 20) ? DW : 20) + 3;
    localparam int CHW      = N1W - C_N1_LO;
    localparam int RCEN     = $clog2(C_DAYS_400Y);
    localparam int QC       = f_quot_width(CHW, RCEN);
    localparam int WCL      = RCEN + C_N1_LO;
    localparam int QCL      = f_quot_width(WCL, RCEN);
    localparam int CW       = N1W - 17;
    localparam int RHR      = $clog2(C_SEC_HOUR);
    localparam int QHR      = f_quot_width(SECW, RHR);
    localparam int RMN      = $clog2(C_SEC_MIN);
    localparam int QMN      = f_quot_width(RHR, RMN);
    localparam int RMD      = $clog2(C_MONTH_MUL);
    localparam int QMD      = f_quot_width(16, RMD);
    localparam int ND6      = (DW + 6) / 6;

    logic [LAT:1] r_vld;
    logic [LAT:1] w_en;

    // ---------------- pipeline control ----------------
    for (genvar gs = 1; gs <= LAT; gs++) begin : g_en
        assign w_en[gs] = o_out.ready || !(&r_vld[LAT:gs]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int s = 2; s <= LAT; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign i_in.ready  = w_en[1];
    assign o_out.valid = r_vld[LAT];

    // ---------------- stages 1-4: seconds to days and seconds of day ----------------
    logic [QA-1:0]       w_dhi_q;
    logic [RDAY-1:0]     w_dhi_r;
    logic [QDL-1:0]      w_dlo_q;
    logic [RDAY-1:0]     w_dlo_r;
    logic [LOW_BITS-1:0] r_s1_low, r_s2_low;
    logic [QA-1:0]       r_s3_qh, r_s4_qh;
    logic [C_SEC_DAY_SHIFT-1:0] r_s3_l7, r_s4_l7;

    e2c_cdiv #(.W(HW), .D(C_SEC_DAY_ODD)) u_day_hi (
        .i_clk  (i_clk),
        .i_en   (w_en[2:1]),
        .i_num  (i_in.epoch_seconds[SECONDS_WIDTH-1:LOW_BITS]),
        .o_quot (w_dhi_q),
        .o_rem  (w_dhi_r)
    );

    e2c_cdiv #(.W(WDL), .D(C_SEC_DAY_ODD)) u_day_lo (
        .i_clk  (i_clk),
        .i_en   (w_en[4:3]),
        .i_num  ({w_dhi_r, r_s2_low[LOW_BITS-1:C_SEC_DAY_SHIFT]}),
        .o_quot (w_dlo_q),
        .o_rem  (w_dlo_r)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[1]) r_s1_low <= i_in.epoch_seconds[LOW_BITS-1:0];
        if (w_en[2]) r_s2_low <= r_s1_low;
        if (w_en[3]) begin
            r_s3_qh <= w_dhi_q;
            r_s3_l7 <= r_s2_low[C_SEC_DAY_SHIFT-1:0];
        end
        if (w_en[4]) begin
            r_s4_qh <= r_s3_qh;
            r_s4_l7 <= r_s3_l7;
        end
    end

    logic [DW-1:0]   w_days;
    logic [SECW-1:0] w_secs;
    logic [N1W-1:0]  w_n1;

    assign w_days = DW'({r_s4_qh, w_dlo_q[C_DAYS_LO-1:0]});
    assign w_secs = {w_dlo_r, r_s4_l7};
    assign w_n1   = {(N1W-2)'(w_days) + (N1W-2)'(C_SHIFT_MARCH), 2'b11};

    // ---------------- stages 5-8: century split, weekday, hour/minute ----------------
    logic [3*0+6*ND6-1:0] w_wsrc;
    logic [8:0]           w_wsum;
    logic [8:0]           r_s5_wsum;
    logic [6:0]           w_w2;
    logic [3:0]           w_w3, w_w4;
    logic [2:0]           w_wday;
    logic [2:0]           r_s6_wday, r_s7_wday, r_s8_wday;

    // 64 = 1 mod 7: sum the base-64 digits, then fold down
    assign w_wsrc = (6*ND6)'(w_days) + (6*ND6)'(C_WDAY_OFFSET);

    always_comb begin
        w_wsum = '0;
        for (int i = 0; i < ND6; i++) begin
            w_wsum = w_wsum + 9'(w_wsrc[6*i +: 6]);
        end
    end

    assign w_w2   = 7'(r_s5_wsum[5:0]) + 7'(r_s5_wsum[8:6]);
    assign w_w3   = 4'(w_w2[2:0]) + 4'(w_w2[5:3]) + 4'(w_w2[6]);
    assign w_w4   = 4'(w_w3[2:0]) + 4'(w_w3[3]);
    assign w_wday = (w_w4 >= 4'd7) ? 3'(w_w4 - 4'd7) : w_w4[2:0];

    logic [QC-1:0]      w_chi_q;
    logic [RCEN-1:0]    w_chi_r;
    logic [QCL-1:0]     w_clo_q;
    logic [RCEN-1:0]    w_clo_r;
    logic [C_N1_LO-1:0] r_s5_n1lo, r_s6_n1lo;
    logic [QC-1:0]      r_s7_qc, r_s8_qc;
    logic [QHR-1:0]     w_hr_q;
    logic [RHR-1:0]     w_hr_r;
    logic [QMN-1:0]     w_mn_q;
    logic [RMN-1:0]     w_mn_r;
    logic [4:0]         r_s7_hr, r_s8_hr;

    e2c_cdiv #(.W(CHW), .D(C_DAYS_400Y)) u_cen_hi (
        .i_clk  (i_clk),
        .i_en   (w_en[6:5]),
        .i_num  (w_n1[N1W-1:C_N1_LO]),
        .o_quot (w_chi_q),
        .o_rem  (w_chi_r)
    );

    e2c_cdiv #(.W(WCL), .D(C_DAYS_400Y)) u_cen_lo (
        .i_clk  (i_clk),
        .i_en   (w_en[8:7]),
        .i_num  ({w_chi_r, r_s6_n1lo}),
        .o_quot (w_clo_q),
        .o_rem  (w_clo_r)
    );

    e2c_cdiv #(.W(SECW), .D(C_SEC_HOUR)) u_tod_hr (
        .i_clk  (i_clk),
        .i_en   (w_en[6:5]),
        .i_num  (w_secs),
        .o_quot (w_hr_q),
        .o_rem  (w_hr_r)
    );

    e2c_cdiv #(.W(RHR), .D(C_SEC_MIN)) u_tod_mn (
        .i_clk  (i_clk),
        .i_en   (w_en[8:7]),
        .i_num  (w_hr_r),
        .o_quot (w_mn_q),
        .o_rem  (w_mn_r)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_n1lo <= w_n1[C_N1_LO-1:0];
            r_s5_wsum <= w_wsum;
        end
        if (w_en[6]) begin
            r_s6_n1lo <= r_s5_n1lo;
            r_s6_wday <= w_wday;
        end
        if (w_en[7]) begin
            r_s7_qc   <= w_chi_q;
            r_s7_hr   <= w_hr_q[4:0];
            r_s7_wday <= r_s6_wday;
        end
        if (w_en[8]) begin
            r_s8_qc   <= r_s7_qc;
            r_s8_hr   <= r_s7_hr;
            r_s8_wday <= r_s7_wday;
        end
    end

    // ---------------- stage 9: year of century ----------------
    logic [CW-1:0] w_cent;
    logic [15:0]   w_doc;
    logic [39:0]   w_ymul;
    logic [15:0]   r_s9_cent;
    logic [15:0]   r_s9_doc;
    logic [6:0]    r_s9_yoc;
    t_tod          r_tod [C_STG_TOD:LAT];

    assign w_cent = CW'({r_s8_qc, w_clo_q[C_N1_LO-1:0]});
    assign w_doc  = w_clo_r[RCEN-1:2];
    assign w_ymul = 40'({w_doc, 2'b11}) * 40'(C_YEAR_MUL);

    always_ff @(posedge i_clk) begin
        if (w_en[C_STG_TOD]) begin
            r_s9_cent <= 16'(w_cent);
            r_s9_doc  <= w_doc;
            r_s9_yoc  <= w_ymul[38:32];
            r_tod[C_STG_TOD] <= '{weekday: r_s8_wday, hour: r_s8_hr,
                                  minute: w_mn_q[5:0], second: w_mn_r};
        end
        for (int s = C_STG_TOD + 1; s <= LAT; s++) begin
            if (w_en[s]) r_tod[s] <= r_tod[s-1];
        end
    end

    // ---------------- stage 10: day of March-based year, leap, base year ----------------
    logic [8:0]  w_doy;
    logic        w_leap;
    logic [8:0]  r_s10_doy;
    logic        r_s10_leap;
    logic [15:0] r_s10_year;

    assign w_doy  = 9'(r_s9_doc - 16'(r_s9_yoc) * 16'd365 - 16'(r_s9_yoc[6:2]));
    // century years are leap only every fourth century
    assign w_leap = (r_s9_yoc != 7'd0) ? (r_s9_yoc[1:0] == 2'd0) : (r_s9_cent[1:0] == 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r_s10_doy  <= w_doy;
            r_s10_leap <= w_leap;
            r_s10_year <= r_s9_cent * 16'd100 + 16'(r_s9_yoc);
        end
    end

    // ---------------- stage 11: month code, January/February fold ----------------
    logic [19:0] w_n3;
    logic        w_janfeb;
    logic [8:0]  w_yday;
    logic [19:0] r_s11_n3;
    logic        r_s11_janfeb;
    logic [8:0]  r_s11_yday;
    logic [15:0] r_s11_year;

    assign w_n3     = 20'(r_s10_doy) * 20'(C_MONTH_MUL) + 20'(C_MONTH_ADD);
    assign w_janfeb = (r_s10_doy >= 9'(C_JAN_DOY));
    assign w_yday   = w_janfeb ? (r_s10_doy - 9'(C_JAN_DOY) + 9'd1)
                               : (r_s10_doy + 9'(C_JAN_FEB_DAYS) + 9'(r_s10_leap) + 9'd1);

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            r_s11_n3     <= w_n3;
            r_s11_janfeb <= w_janfeb;
            r_s11_yday   <= w_yday;
            r_s11_year   <= r_s10_year + 16'(w_janfeb);
        end
    end

    // ---------------- stages 12-14: day of month, output register ----------------
    logic [QMD-1:0] w_md_q;
    logic [RMD-1:0] w_md_r;
    logic [3:0]     r_s12_month, r_s13_month;
    logic [8:0]     r_s12_yday, r_s13_yday;
    logic [15:0]    r_s12_year, r_s13_year;
    logic [15:0]    r_o_year;
    logic [3:0]     r_o_month;
    logic [4:0]     r_o_mday;
    logic [8:0]     r_o_yday;

    e2c_cdiv #(.W(16), .D(C_MONTH_MUL)) u_mday (
        .i_clk  (i_clk),
        .i_en   (w_en[13:12]),
        .i_num  (r_s11_n3[15:0]),
        .o_quot (w_md_q),
        .o_rem  (w_md_r)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[12]) begin
            r_s12_month <= r_s11_janfeb ? (r_s11_n3[19:16] - 4'd12) : r_s11_n3[19:16];
            r_s12_yday  <= r_s11_yday;
            r_s12_year  <= r_s11_year;
        end
        if (w_en[13]) begin
            r_s13_month <= r_s12_month;
            r_s13_yday  <= r_s12_yday;
            r_s13_year  <= r_s12_year;
        end
        if (w_en[LAT]) begin
            r_o_year  <= r_s13_year;
            r_o_month <= r_s13_month;
            r_o_mday  <= 5'(w_md_q) + 5'd1;
            r_o_yday  <= r_s13_yday;
        end
    end

    assign o_out.year         = r_o_year;
    assign o_out.month        = r_o_month;
    assign o_out.day_of_month = r_o_mday;
    assign o_out.year_day     = r_o_yday;
    assign o_out.weekday      = r_tod[LAT].weekday;
    assign o_out.hour         = r_tod[LAT].hour;
    assign o_out.minute       = r_tod[LAT].minute;
    assign o_out.second       = r_tod[LAT].second;

endmodule

// ===== rtl/e2c_cdiv.sv =====
`timescale 1ns / 1ps
// Two-stage divider by a constant: reciprocal multiply, then quotient and remainder.
// Depends on e2c_pkg (f_quot_width).
module e2c_cdiv #(
    parameter int W  = 16,
    parameter int D  = 3,
    parameter int RW = $clog2(D),
    parameter int QW = e2c_pkg::f_quot_width(W, RW)
) (
    input  logic          i_clk,
    input  logic [1:0]    i_en,
    input  logic [W-1:0]  i_num,
    output logic [QW-1:0] o_quot,
    output logic [RW-1:0] o_rem
);
    import e2c_pkg::*;

    // ceil(2^K / D) is exact for every W-bit dividend since the rounding error is below 2^RW
    localparam int K  = W + RW;
    localparam int MW = W + 2;
    localparam int PW = K + QW;
    localparam longint unsigned C_RECIP_L = ((64'd1 << K) + D - 1) / D;
    localparam logic [MW-1:0]   C_RECIP   = MW'(C_RECIP_L);
    localparam logic [W-1:0]    C_DIV_W   = W'(D);

    logic [PW-1:0] r_prod;
    logic [W-1:0]  r_num;
    logic [QW-1:0] r_quot;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] w_quot;
    logic [W-1:0]  w_rem;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= PW'(i_num) * PW'(C_RECIP);
            r_num  <= i_num;
        end
    end

    // remainder is below 2^W, so modulo-2^W arithmetic is enough
    assign w_quot = r_prod[PW-1:K];
    assign w_rem  = r_num - W'(w_quot) * C_DIV_W;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_quot <= w_quot;
            r_rem  <= RW'(w_rem);
        end
    end

    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== verif/tb_epoch_seconds_to_calendar_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for epoch_seconds_to_calendar_core: drives epoch
// timestamps, predicts each calendar result locally and checks them in order.
// Depends on e2c_pkg, e2c_if and the core RTL.
module tb_epoch_seconds_to_calendar_core;
    import e2c_pkg::*;

    localparam int SW = C_SECONDS_WIDTH;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [8:0]  yday;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_calendar;

    // Epoch day numbers of useful calendar landmarks
    localparam longint unsigned DAY_1999_12_31 = 10956;
    localparam longint unsigned DAY_2000_01_01 = 10957;
    localparam longint unsigned DAY_2000_02_29 = 11016;
    localparam longint unsigned DAY_2000_03_01 = 11017;
    localparam longint unsigned DAY_2000_12_31 = 11322;
    localparam longint unsigned DAY_2100_02_28 = 47540;
    localparam longint unsigned DAY_2100_03_01 = 47541;
    localparam longint unsigned DAYS_4Y        = 1461;
    localparam longint unsigned DAYS_400Y      = 146097;

    logic i_clk;
    logic i_rst_n;

    e2c_in_if #(.SECONDS_WIDTH(SW)) in_ch ();
    e2c_out_if                      out_ch ();

    epoch_seconds_to_calendar_core #(.SECONDS_WIDTH(SW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_calendar pending_dates[$];
    int        n_errors;
    int        n_converted;
    int        n_input_stalls;
    int        send_gap_max;
    int        recv_stall_max;
    int        hold_request;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Civil date from epoch seconds, via a calendar that starts on March 1st
    function automatic t_calendar civil_from_seconds(input logic [SW-1:0] stamp);
        longint unsigned t, days, tod, n1, cent, doc, n2, prod, yoc, doy;
        longint unsigned yr, leap, n3, mon, mday, yday, hr, rem, mn;
        t_calendar c;
        t    = stamp;
        days = t / 86400;
        tod  = t % 86400;
        n1   = 4 * (days + 719468) + 3;
        cent = n1 / 146097;
        doc  = (n1 % 146097) / 4;
        n2   = 4 * doc + 3;
        prod = 64'd2939745 * n2;
        yoc  = prod >> 32;
        doy  = (prod & 64'hFFFF_FFFF) / 2939745 / 4;
        yr   = 100 * cent + yoc;
        leap = (yoc != 0) ? ((yoc % 4) == 0) : ((cent % 4) == 0);
        n3   = 2141 * doy + 132377;
        mon  = n3 >> 16;
        mday = (n3 & 64'hFFFF) / 2141 + 1;
        // fold January and February into the next year
        if (doy >= 306) begin
            yr   = yr + 1;
            mon  = mon - 12;
            yday = doy - 306;
        end else begin
            yday = doy + 59 + leap;
        end
        hr  = tod / 3600;
        rem = tod - hr * 3600;
        mn  = rem / 60;
        c.year    = yr[15:0];
        c.month   = mon[3:0];
        c.mday    = mday[4:0];
        c.yday    = 9'(yday + 1);
        c.weekday = 3'((days + 4) % 7);
        c.hour    = hr[4:0];
        c.minute  = mn[5:0];
        c.second  = 6'(rem - mn * 60);
        return c;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // Result side: check every transfer, then hold ready low for a drawn stall
    initial begin
        int        stall_left;
        int        hold_left;
        t_calendar want;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_dates.size() == 0) begin
                    $error("calendar result with no conversion pending");
                    n_errors++;
                end else begin
                    want = pending_dates.pop_front();
                    compare_field("year",         want.year,    out_ch.year);
                    compare_field("month",        want.month,   out_ch.month);
                    compare_field("day_of_month", want.mday,    out_ch.day_of_month);
                    compare_field("year_day",     want.yday,    out_ch.year_day);
                    compare_field("weekday",      want.weekday, out_ch.weekday);
                    compare_field("hour",         want.hour,    out_ch.hour);
                    compare_field("minute",       want.minute,  out_ch.minute);
                    compare_field("second",       want.second,  out_ch.second);
                    n_converted++;
                end
                stall_left = $urandom_range(0, recv_stall_max);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one timestamp and return at the edge where it transfers. Valid stays
    // high afterwards, so the caller must not let time pass before the next send.
    task automatic send_seconds(input logic [SW-1:0] stamp);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.epoch_seconds <= stamp;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            n_input_stalls++;
            @(posedge i_clk);
        end
        pending_dates.push_back(civil_from_seconds(stamp));
    endtask

    task automatic set_idling(input int send_max, input int recv_max);
        send_gap_max   = send_max;
        recv_stall_max = recv_max;
    endtask

    // Vary idling by chunk: none, one side only, or both
    task automatic shuffle_idling();
        case ($urandom_range(0, 3))
            0:       set_idling(0, 0);
            1:       set_idling(17, 0);
            2:       set_idling(0, 17);
            default: set_idling(17, 17);
        endcase
    endtask

    function automatic logic [SW-1:0] stamp_of(input longint unsigned days);
        longint unsigned tod;
        case ($urandom_range(0, 3))
            0:       tod = 0;
            1:       tod = 86399;
            default: tod = $urandom_range(0, 86399);
        endcase
        return SW'(days * 86400 + tod);
    endfunction

    task automatic test_directed();
        logic [SW-1:0] edges[$];
        edges = '{40'd0, 40'd1, 40'd59, 40'd60, 40'd3599, 40'd3600, 40'd86399, 40'd86400,
                  40'd946684799, 40'd946684800, 40'd951782399, 40'd951782400,
                  40'd951868800, 40'd978307199, 40'd4107542399, 40'd4107542400,
                  40'hFF_FFFF_FFFF, 40'h1_0000_0000, 40'hFF_FFFF_FFFF - 40'd86400,
                  40'h80_0000_0000, 40'h55_5555_5555, 40'hAA_AAAA_AAAA};
        set_idling(0, 0);
        foreach (edges[i]) send_seconds(edges[i]);
    endtask

    // Leap days, year ends and the 2100 non-leap February, shifted by whole
    // 400-year cycles so they land across the full input range
    task automatic test_leap_and_century(input int count);
        longint unsigned landmarks[$];
        longint unsigned days;
        int              pick;
        landmarks = '{DAY_2000_02_29, DAY_2000_03_01, DAY_1999_12_31, DAY_2000_01_01,
                      DAY_2000_12_31, DAY_2100_02_28, DAY_2100_03_01};
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) shuffle_idling();
            pick = $urandom_range(0, landmarks.size() - 1);
            days = landmarks[pick] + DAYS_400Y * $urandom_range(0, 85);
            // four-year steps keep a 2000s landmark inside the same century
            if (landmarks[pick] < DAY_2100_02_28)
                days = days + DAYS_4Y * $urandom_range(0, 24);
            days = days + $urandom_range(0, 2) - 1;
            send_seconds(stamp_of(days));
        end
    endtask

    task automatic test_full_span(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) shuffle_idling();
            send_seconds({8'($urandom), 32'($urandom)});
        end
    endtask

    task automatic test_epoch32(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) shuffle_idling();
            send_seconds(SW'($urandom));
        end
    endtask

    // Hold the result side off long enough for the pipeline to fill and stall input
    task automatic test_backpressure(input int count);
        set_idling(0, 0);
        hold_request = 80;
        for (int i = 0; i < count; i++)
            send_seconds(stamp_of($urandom_range(0, 12725828)));
    endtask

    initial begin
        n_errors       = 0;
        n_converted    = 0;
        n_input_stalls = 0;
        hold_request   = 0;
        set_idling(0, 0);
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.epoch_seconds <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_leap_and_century(180);
        test_backpressure(60);
        test_full_span(180);
        test_epoch32(60);
        in_ch.valid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (C_LATENCY + 4) @(posedge i_clk);

        $display("Checked %0d conversions: edge timestamps, leap days, century years,",
                 n_converted);
        $display("the full 40-bit range and output back-pressure (%0d input stall cycles).",
                 n_input_stalls);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
